@@ hw/rtl/pbsi_pkg.sv @@
// ----------------------------------------------------------------------------
// pbsi_pkg: shared types and constants
// Kinds, status codes and the control struct for the bitmap stream iterator.
// ----------------------------------------------------------------------------
package pbsi_pkg;

  localparam int MAX_STREAMS_DEF  = 256;
  localparam int BITMAP_WORDS_DEF = 4;
  localparam int TAG_BITS_DEF     = 16;
  localparam int PRIO_BITS        = 8;
  localparam int KIND_BITS        = 3;
  localparam int STATUS_BITS      = 2;

  localparam logic [KIND_BITS-1:0] K_CLEAR    = 3'd0;
  localparam logic [KIND_BITS-1:0] K_ADD      = 3'd1;
  localparam logic [KIND_BITS-1:0] K_FIRST    = 3'd2;
  localparam logic [KIND_BITS-1:0] K_NEXT     = 3'd3;
  localparam logic [KIND_BITS-1:0] K_DROP_HI  = 3'd4;
  localparam logic [KIND_BITS-1:0] K_DROP_NHI = 3'd5;

  localparam logic [STATUS_BITS-1:0] ST_STREAM = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_DONE   = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_ACK    = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic                   load;
    logic                   find_b;
    logic                   read_slot;
    logic                   exec;
  } pbsi_cmd_t;

endpackage

@@ hw/rtl/pbsi_ctrl.sv @@
// ----------------------------------------------------------------------------
// pbsi_ctrl: controller
// Sequences load, second search, slot read, execute and result hand-off.
// ----------------------------------------------------------------------------
module pbsi_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic               out_fire,
  output logic               in_ready,
  output logic               out_valid,
  output pbsi_pkg::pbsi_cmd_t cmd
);
  import pbsi_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FINDB  = 3'd1;
  localparam logic [2:0] S_RDSLOT = 3'd2;
  localparam logic [2:0] S_EXEC   = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_FINDB;
      S_FINDB: state_nxt = S_RDSLOT;
      S_RDSLOT: state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_OUT;
      S_OUT:  if (out_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = (state_r == S_OUT);
  assign cmd.load      = in_fire;
  assign cmd.find_b    = (state_r == S_FINDB);
  assign cmd.read_slot = (state_r == S_RDSLOT);
  assign cmd.exec      = (state_r == S_EXEC);
endmodule

@@ hw/rtl/pbsi_dp.sv @@
// ----------------------------------------------------------------------------
// pbsi_dp: datapath
// Bitmap, level and slot stores, find-next-set and result register.
// ----------------------------------------------------------------------------
module pbsi_dp #(
  parameter int MAX_STREAMS  = pbsi_pkg::MAX_STREAMS_DEF,
  parameter int BITMAP_WORDS = pbsi_pkg::BITMAP_WORDS_DEF,
  parameter int TAG_BITS     = pbsi_pkg::TAG_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pbsi_pkg::pbsi_cmd_t             cmd,
  input  logic [pbsi_pkg::KIND_BITS-1:0]  kind,
  input  logic [TAG_BITS-1:0]             tag_in,
  input  logic [pbsi_pkg::PRIO_BITS-1:0]  prio_in,
  input  logic                            crit_in,
  output logic [pbsi_pkg::STATUS_BITS-1:0] status,
  output logic [TAG_BITS-1:0]             tag_out,
  output logic [pbsi_pkg::PRIO_BITS-1:0]  prio_out
);
  import pbsi_pkg::*;

  localparam int LEVELS = 64 * BITMAP_WORDS;
  localparam int LB     = $clog2(LEVELS);
  localparam int LW     = LB + 1;
  localparam int SB     = $clog2(MAX_STREAMS);
  localparam int CB     = SB + 1;

  logic [SB-1:0]       head_m  [LEVELS];
  logic [SB-1:0]       tail_m  [LEVELS];
  logic [CB-1:0]       ncnt_m  [LEVELS];
  logic [TAG_BITS-1:0] stag_m  [MAX_STREAMS];
  logic [SB-1:0]       slink_m [MAX_STREAMS];

  logic [LEVELS-1:0]      bm_r, bm_nxt;
  logic [MAX_STREAMS-1:0] lval_r, lval_nxt;
  logic [CB-1:0]          used_r, used_nxt;
  logic [LB-1:0]          cur_r, cur_nxt;
  logic [SB-1:0]          pend_r, pend_nxt;
  logic                   pend_v_r, pend_v_nxt;
  logic [STATUS_BITS-1:0] status_r, status_nxt;
  logic [TAG_BITS-1:0]    otag_r, otag_nxt;
  logic [PRIO_BITS-1:0]   oprio_r, oprio_nxt;

  logic [KIND_BITS-1:0] kind_r;
  logic [TAG_BITS-1:0]  tag_r;
  logic [LB-1:0]        lvl_r;
  logic                 crit_r;
  logic                 a_ok_r, b_ok_r;
  logic [LB-1:0]        a_r, b_r;
  logic [SB-1:0]        hd_r, tl_r;
  logic [CB-1:0]        nc_r;
  logic [TAG_BITS-1:0]  rd_tag_r;
  logic [SB-1:0]        rd_link_r;
  logic                 rd_val_r;

  logic [LB-1:0]     lvl_c, nc_addr_c;
  logic [LW-1:0]     start_c, a_c, b_c;
  logic [SB-1:0]     slot_c, s_c;
  logic              occ_c, full_c;
  logic [LEVELS-1:0] sel_c;

  // Lowest set bit at or above a start level.
  function automatic logic [LW-1:0] ffs(input logic [LEVELS-1:0] v,
                                        input logic [LW-1:0] st);
    logic [LEVELS-1:0] m;
    logic [LW-1:0] r;
    m = v & ({LEVELS{1'b1}} << st);
    r = {1'b1, {LB{1'b0}}};
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (m[i]) r = {1'b0, LB'(i)};
    end
    return r;
  endfunction

  always_comb begin
    lvl_c = (prio_in >= PRIO_BITS'(LEVELS - 1)) ? LB'(LEVELS - 1) : LB'(prio_in);
    start_c = (kind == K_NEXT) ? ({1'b0, cur_r} + LW'(1)) : '0;
    a_c = ffs(bm_r, start_c);
    b_c = ffs(bm_r, {1'b0, a_r} + LW'(1));
    nc_addr_c = (kind_r == K_ADD) ? lvl_r : a_r;
    slot_c = (kind_r == K_NEXT && pend_v_r) ? pend_r : hd_r;
  end

  assign occ_c  = bm_r[lvl_r];
  assign full_c = (used_r >= CB'(MAX_STREAMS));
  assign s_c    = used_r[SB-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind; tag_r <= tag_in; lvl_r <= lvl_c; crit_r <= crit_in;
      a_ok_r <= !a_c[LB]; a_r <= a_c[LB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.find_b) begin
      b_ok_r <= !b_c[LB]; b_r <= b_c[LB-1:0];
      hd_r <= head_m[a_r];
      tl_r <= tail_m[lvl_r];
      nc_r <= ncnt_m[nc_addr_c];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_slot) begin
      rd_tag_r  <= stag_m[slot_c];
      rd_link_r <= slink_m[slot_c];
      rd_val_r  <= lval_r[slot_c];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && kind_r == K_ADD && !full_c) begin
      stag_m[s_c] <= tag_r;
      if (!occ_c) head_m[lvl_r] <= s_c;
      else slink_m[tl_r] <= s_c;
      tail_m[lvl_r] <= s_c;
      ncnt_m[lvl_r] <= (occ_c ? nc_r : '0) + CB'(!crit_r);
    end
  end

  always_comb begin
    bm_nxt = bm_r; lval_nxt = lval_r; used_nxt = used_r; cur_nxt = cur_r;
    pend_nxt = pend_r; pend_v_nxt = pend_v_r;
    status_nxt = status_r; otag_nxt = otag_r; oprio_nxt = oprio_r;
    sel_c = '0;
    if (cmd.exec) begin
      status_nxt = ST_ACK; otag_nxt = '0; oprio_nxt = '0;
      case (kind_r)
        K_CLEAR: begin
          bm_nxt = '0; lval_nxt = '0; used_nxt = '0; cur_nxt = '0;
          pend_nxt = '0; pend_v_nxt = 1'b0;
        end
        K_ADD: begin
          if (full_c) status_nxt = ST_FULL;
          else begin
            used_nxt = used_r + CB'(1);
            if (!occ_c) bm_nxt[lvl_r] = 1'b1;
            else lval_nxt[tl_r] = 1'b1;
          end
        end
        K_FIRST: begin
          if (!a_ok_r) begin
            status_nxt = ST_DONE; cur_nxt = '0; pend_v_nxt = 1'b0;
          end else begin
            status_nxt = ST_STREAM; cur_nxt = a_r; otag_nxt = rd_tag_r;
            oprio_nxt = PRIO_BITS'(a_r); pend_nxt = rd_link_r; pend_v_nxt = rd_val_r;
          end
        end
        K_NEXT: begin
          if (pend_v_r) begin
            status_nxt = ST_STREAM; otag_nxt = rd_tag_r; oprio_nxt = PRIO_BITS'(cur_r);
            pend_nxt = rd_link_r; pend_v_nxt = rd_val_r;
          end else if (!a_ok_r) status_nxt = ST_DONE;
          else begin
            status_nxt = ST_STREAM; cur_nxt = a_r; otag_nxt = rd_tag_r;
            oprio_nxt = PRIO_BITS'(a_r); pend_nxt = rd_link_r; pend_v_nxt = rd_val_r;
          end
        end
        K_DROP_HI, K_DROP_NHI: begin
          if (a_ok_r && b_ok_r) begin
            sel_c[a_r] = 1'b1;
            cur_nxt = a_r;
            if (nc_r == '0) begin
              sel_c[b_r] = 1'b1; cur_nxt = b_r;
            end
            bm_nxt = (kind_r == K_DROP_HI) ? (bm_r & ~sel_c) : sel_c;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bm_r <= '0; lval_r <= '0; used_r <= '0; cur_r <= '0;
      pend_r <= '0; pend_v_r <= 1'b0;
      status_r <= '0; otag_r <= '0; oprio_r <= '0;
    end else begin
      bm_r <= bm_nxt; lval_r <= lval_nxt; used_r <= used_nxt; cur_r <= cur_nxt;
      pend_r <= pend_nxt; pend_v_r <= pend_v_nxt;
      status_r <= status_nxt; otag_r <= otag_nxt; oprio_r <= oprio_nxt;
    end
  end

  assign status   = status_r;
  assign tag_out  = otag_r;
  assign prio_out = oprio_r;
endmodule

@@ hw/rtl/priority_bitmap_stream_iterator_top.sv @@
// ----------------------------------------------------------------------------
// priority_bitmap_stream_iterator_top: priority bitmap stream iterator
// Per-level FIFO lists of stream tags with find-next-set iteration.
// ----------------------------------------------------------------------------
// Channel | Direction | tdata (low bit up)                      | tuser
// in_     | slave     | stream_tag, priority_req, critical      | kind
// out_    | master    | out_tag, out_priority                   | status
//
// Items are handled one at a time: the accepting edge also runs the first
// bitmap search, then the second search and the level store reads follow,
// then the slot store read, the state update and the offer of the result.
// The next item is taken the cycle after delivery.
// Reset clears the bitmap, link flags and used-slot counter at once; no clearing pass.
// A stalled result holds the block and in_tready stays low until it is taken.
module priority_bitmap_stream_iterator_top #(
  parameter int MAX_STREAMS  = pbsi_pkg::MAX_STREAMS_DEF,
  parameter int BITMAP_WORDS = pbsi_pkg::BITMAP_WORDS_DEF,
  parameter int TAG_BITS     = pbsi_pkg::TAG_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // stream_tag, priority_req, critical, zero fill
  input  logic [((TAG_BITS + 9 + 7) / 8) * 8 - 1:0] in_tdata,
  // kind
  input  logic [pbsi_pkg::KIND_BITS-1:0] in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // out_tag, out_priority, zero fill
  output logic [((TAG_BITS + 8 + 7) / 8) * 8 - 1:0] out_tdata,
  // status
  output logic [pbsi_pkg::STATUS_BITS-1:0] out_tuser
);
  import pbsi_pkg::*;

  localparam int OW = ((TAG_BITS + 8 + 7) / 8) * 8;

  pbsi_cmd_t cmd;
  logic [TAG_BITS-1:0] tag_o;
  logic [PRIO_BITS-1:0] prio_o;

  pbsi_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_fire(in_tvalid && in_tready), .out_fire(out_tvalid && out_tready),
    .in_ready(in_tready), .out_valid(out_tvalid), .cmd(cmd)
  );

  pbsi_dp #(.MAX_STREAMS(MAX_STREAMS), .BITMAP_WORDS(BITMAP_WORDS),
    .TAG_BITS(TAG_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .kind(in_tuser),
    .tag_in(in_tdata[TAG_BITS-1:0]),
    .prio_in(in_tdata[TAG_BITS +: PRIO_BITS]),
    .crit_in(in_tdata[TAG_BITS + PRIO_BITS]),
    .status(out_tuser), .tag_out(tag_o), .prio_out(prio_o)
  );

  assign out_tdata = OW'({prio_o, tag_o});
endmodule

@@ dv/tb_priority_bitmap_stream_iterator_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_priority_bitmap_stream_iterator_top: self-checking bench for the iterator
// Drives clear, add, first, next and both drop kinds through the input stream,
// predicts every status, tag and level in a local model of the bitmap and the
// per-level lists, and compares each result item in order under random idling.
// ----------------------------------------------------------------------------
module tb_priority_bitmap_stream_iterator_top;
  import pbsi_pkg::*;

  localparam int NLEV  = 256;
  localparam int NSLOT = MAX_STREAMS_DEF;
  localparam int LIMIT = 600000;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [15:0]            tag;
    logic [7:0]             prio;
  } answer_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [31:0] in_tdata;
  logic [KIND_BITS-1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [23:0] out_tdata;
  logic [STATUS_BITS-1:0] out_tuser;

  // Local copy of the iterator state.
  logic [NLEV-1:0] occ;
  int   head_of [NLEV];
  int   tail_of [NLEV];
  int   nc_count [NLEV];
  logic [15:0] slot_tag [NSLOT];
  int   slot_next [NSLOT];
  bit   slot_next_ok [NSLOT];
  int   used_slots;
  int   cur_level;
  int   pend_slot;
  bit   pend_ok;

  answer_t answers_due[$];
  int   errors;
  int   items_sent;
  int   results_seen;
  int   cycles;
  bit   calm;
  bit   hold_req;
  int   hold_left;
  int   kind_hits [6];

  priority_bitmap_stream_iterator_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic int lowest_from(int start);
    for (int i = start; i < NLEV; i++) begin
      if (occ[i]) return i;
    end
    return -1;
  endfunction

  function automatic void clear_state();
    occ = '0;
    used_slots = 0;
    cur_level = 0;
    pend_slot = 0;
    pend_ok = 0;
  endfunction

  function automatic answer_t stream_from_slot(int s);
    answer_t a;
    pend_ok = slot_next_ok[s];
    pend_slot = slot_next[s];
    a.status = ST_STREAM;
    a.tag = slot_tag[s];
    a.prio = cur_level[7:0];
    return a;
  endfunction

  function automatic void drop_levels(bit high);
    logic [NLEV-1:0] sel;
    int lo;
    int nx;
    lo = lowest_from(0);
    if (lo < 0) return;
    nx = lowest_from(lo + 1);
    if (nx < 0) return;
    sel = '0;
    sel[lo] = 1'b1;
    cur_level = lo;
    if (nc_count[lo] == 0) begin
      sel[nx] = 1'b1;
      cur_level = nx;
    end
    occ = high ? (occ & ~sel) : sel;
  endfunction

  function automatic answer_t iterate(logic [KIND_BITS-1:0] kind, logic [15:0] tag,
                                      logic [7:0] prio, logic crit);
    answer_t a;
    int lv;
    int s;
    a = '{status: ST_ACK, tag: '0, prio: '0};
    case (kind)
      K_CLEAR: clear_state();
      K_ADD: begin
        if (used_slots >= NSLOT) begin
          a.status = ST_FULL;
        end else begin
          s = used_slots++;
          slot_tag[s] = tag;
          slot_next_ok[s] = 0;
          slot_next[s] = 0;
          if (!occ[prio]) begin
            occ[prio] = 1'b1;
            head_of[prio] = s;
            tail_of[prio] = s;
            nc_count[prio] = 0;
          end else begin
            slot_next[tail_of[prio]] = s;
            slot_next_ok[tail_of[prio]] = 1;
            tail_of[prio] = s;
          end
          if (!crit) nc_count[prio]++;
        end
      end
      K_FIRST: begin
        lv = lowest_from(0);
        if (lv < 0) begin
          cur_level = 0;
          pend_ok = 0;
          a.status = ST_DONE;
        end else begin
          cur_level = lv;
          a = stream_from_slot(head_of[lv]);
        end
      end
      K_NEXT: begin
        if (pend_ok) begin
          a = stream_from_slot(pend_slot);
        end else begin
          lv = lowest_from(cur_level + 1);
          if (lv < 0) begin
            a.status = ST_DONE;
          end else begin
            cur_level = lv;
            a = stream_from_slot(head_of[lv]);
          end
        end
      end
      K_DROP_HI: drop_levels(1);
      K_DROP_NHI: drop_levels(0);
      default: ;
    endcase
    return a;
  endfunction

  task automatic send_item(logic [KIND_BITS-1:0] kind, logic [15:0] tag = '0,
                           logic [7:0] prio = '0, logic crit = 1'b0);
    if (!calm && $urandom_range(99) < 13) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {7'd0, crit, prio, tag};
    do @(posedge clk); while (!in_tready);
    answers_due.push_back(iterate(kind, tag, prio, crit));
    items_sent++;
    if (kind < 6) kind_hits[kind]++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (hold_req && hold_left == 0) hold_left <= 400;
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 13);
    end
  end

  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (answers_due.size() == 0) begin
        $error("result item with nothing expected: status %0d", out_tuser);
        errors++;
      end else begin
        want = answers_due.pop_front();
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_tuser);
          errors++;
        end
        if (out_tdata[15:0] !== want.tag) begin
          $error("out_tag: expected %0h, actual %0h", want.tag, out_tdata[15:0]);
          errors++;
        end
        if (out_tdata[23:16] !== want.prio) begin
          $error("out_priority: expected %0d, actual %0d", want.prio, out_tdata[23:16]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(K_FIRST);
    send_item(K_NEXT);
    send_item(K_DROP_HI);
    send_item(K_ADD, 16'hFFFF, 8'd255, 1'b1);
    send_item(K_DROP_NHI);
    send_item(K_ADD, 16'h0000, 8'd0, 1'b0);
    send_item(K_ADD, 16'h1234, 8'd0, 1'b1);
    send_item(K_ADD, 16'h5A5A, 8'd7, 1'b1);
    send_item(K_FIRST);
    repeat (4) send_item(K_NEXT);
    send_item(K_DROP_HI);
    send_item(K_FIRST);
    send_item(K_NEXT);
    send_item(K_ADD, 16'hA5A5, 8'd3, 1'b1);
    send_item(K_ADD, 16'h00F0, 8'd9, 1'b0);
    send_item(K_DROP_NHI);
    send_item(K_NEXT);
    send_item(K_FIRST);
    repeat (3) send_item(K_NEXT);
    send_item(K_CLEAR);
    drain();
  endtask

  task automatic test_store_full();
    send_item(K_CLEAR);
    for (int i = 0; i < NSLOT; i++) begin
      send_item(K_ADD, 16'($urandom), 8'($urandom_range(0, 3) * 85), 1'($urandom));
    end
    send_item(K_ADD, 16'hBEEF, 8'd1, 1'b0);
    send_item(K_FIRST);
    repeat (6) send_item(K_NEXT);
    send_item(K_CLEAR);
    drain();
  endtask

  task automatic test_backpressure();
    calm = 1;
    hold_req = 1;
    wait (hold_left != 0);
    hold_req = 0;
    for (int i = 0; i < 12; i++) send_item(K_ADD, 16'($urandom), 8'(i % 4), 1'b0);
    send_item(K_FIRST);
    repeat (14) send_item(K_NEXT);
    drain();
    calm = 0;
  endtask

  task automatic test_random(int count);
    int r;
    logic [7:0] lv;
    logic [7:0] pool [6];
    for (int i = 0; i < 6; i++) pool[i] = 8'($urandom);
    pool[0] = 8'd0;
    pool[5] = 8'd255;
    for (int n = 0; n < count; n++) begin
      calm = (n >= count / 2) && (n < count / 2 + 300);
      r = $urandom_range(99);
      lv = ($urandom_range(9) < 8) ? pool[$urandom_range(5)] : 8'($urandom);
      if (r < 3) begin
        send_item(K_CLEAR);
        for (int i = 1; i < 5; i++) pool[i] = 8'($urandom);
      end else if (r < 45) send_item(K_ADD, 16'($urandom), lv, ($urandom_range(9) < 4));
      else if (r < 55) send_item(K_FIRST);
      else if (r < 85) send_item(K_NEXT);
      else if (r < 92) send_item(K_DROP_HI);
      else send_item(K_DROP_NHI);
    end
    calm = 0;
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = K_CLEAR;
    out_tready = 1'b0;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    cycles = 0;
    calm = 0;
    hold_req = 0;
    hold_left = 0;
    foreach (kind_hits[i]) kind_hits[i] = 0;
    clear_state();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_store_full();
    test_backpressure();
    test_random(1700);
    $display("Sent %0d items and checked %0d results over %0d cycles.",
             items_sent, results_seen, cycles);
    $display("Kinds: clear %0d, add %0d, first %0d, next %0d, %s %0d, %s %0d.",
             kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3],
             "lowest levels removed", kind_hits[4],
             "lowest levels kept", kind_hits[5]);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
